/* design/cell_undervoltage_monitor_assert.svh */
// assertion macros shared by the monitor modules
`ifndef CELL_UNDERVOLTAGE_MONITOR_ASSERT_SVH
`define CELL_UNDERVOLTAGE_MONITOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CUVM_ASSERT_HOLD(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cuvm assertion failed");

// next-cycle implication, checked outside reset
`define CUVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cuvm assertion failed");

`endif

/* design/cuvm_pkg.sv */
package cuvm_pkg;

    // cell array
    localparam int CELL_COUNT  = 15;
    localparam int CELL_IDX_W  = 4;
    localparam int FLAGS_W     = 15;

    // field widths
    localparam int RAW_W       = 8;
    localparam int CODE_HI_W   = 6;
    localparam int CODE_W      = 14;
    localparam int MV_W        = 13;
    localparam int COUNT_W     = 8;

    // millivolt conversion: code*380/1000 = code*19/50
    localparam int MV_NUM      = 19;
    localparam int MV_DEN      = 50;
    localparam int PROD_W      = 19;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / MV_DEN;
    localparam int WIDE_W      = 2 * PROD_W;

    // register file
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_UV_THRESHOLD   = 2'd0,
        REG_RECOVERY_LEVEL = 2'd1,
        REG_TRIP_COUNT     = 2'd2,
        REG_CLEAR_COUNT    = 2'd3
    } t_reg_index;

    localparam logic [MV_W-1:0]    UV_THRESHOLD_RST   = MV_W'(2800);
    localparam logic [MV_W-1:0]    RECOVERY_LEVEL_RST = MV_W'(3000);
    localparam logic [COUNT_W-1:0] TRIP_COUNT_RST     = COUNT_W'(30);
    localparam logic [COUNT_W-1:0] CLEAR_COUNT_RST    = COUNT_W'(60);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MV_W-1:0]    uv_threshold_mv;
        logic [MV_W-1:0]    recovery_level_mv;
        logic [COUNT_W-1:0] trip_count;
        logic [COUNT_W-1:0] clear_count;
    } t_cfg;

    typedef enum logic [1:0] {
        CLS_LOW  = 2'd0,
        CLS_HIGH = 2'd1,
        CLS_MID  = 2'd2
    } t_cls;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] idx;
        logic                  idx_ok;
        logic [MV_W-1:0]       mv;
        t_cls                  cls;
    } t_item;

endpackage

/* design/cuvm_front.sv */
module cuvm_front import cuvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CELL_IDX_W-1:0] i_cell_index,
    input  logic [RAW_W-1:0]      i_raw_high,
    input  logic [RAW_W-1:0]      i_raw_low,
    output logic                  o_push,
    input  logic                  i_push_ready,
    output t_item                 o_item
);

    logic                  r_v1, r_v2, r_v3;
    logic [CELL_IDX_W-1:0] r1_idx, r2_idx, r3_idx;
    logic [PROD_W-1:0]     r1_prod, r2_prod;
    logic [MV_W-1:0]       r2_q0, r3_mv;

    logic                  adv;
    logic [CODE_W-1:0]     code;
    logic [PROD_W-1:0]     n1_prod;
    logic [WIDE_W-1:0]     wide;
    logic [PROD_W-1:0]     back_mul;
    logic [PROD_W-1:0]     rem;
    logic [MV_W-1:0]       n3_mv;

    // whole pipe moves when its last slot is free or draining
    assign adv     = !r_v3 || i_push_ready;
    assign o_ready = adv;

    // stage 1: 14-bit code times 19
    assign code    = {i_raw_high[CODE_HI_W-1:0], i_raw_low};
    assign n1_prod = PROD_W'(code) * PROD_W'(MV_NUM);

    // stage 2: reciprocal estimate of prod/50, low by at most one
    assign wide = WIDE_W'(r1_prod) * WIDE_W'(RECIP);

    // stage 3: one correction step
    assign back_mul = PROD_W'(r2_q0) * PROD_W'(MV_DEN);
    assign rem      = r2_prod - back_mul;
    assign n3_mv    = (rem >= PROD_W'(MV_DEN)) ? (r2_q0 + MV_W'(1)) : r2_q0;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_idx  <= i_cell_index;
            r1_prod <= n1_prod;
            r2_idx  <= r1_idx;
            r2_prod <= r1_prod;
            r2_q0   <= wide[RECIP_SHIFT +: MV_W];
            r3_idx  <= r2_idx;
            r3_mv   <= n3_mv;
        end
    end

    // classify against thresholds, below-threshold test wins
    always_comb begin
        o_item.idx    = r3_idx;
        o_item.idx_ok = ({1'b0, r3_idx} < (CELL_IDX_W + 1)'(CELL_COUNT));
        o_item.mv     = r3_mv;
        if (r3_mv < i_cfg.uv_threshold_mv) begin
            o_item.cls = CLS_LOW;
        end else if (r3_mv > i_cfg.recovery_level_mv) begin
            o_item.cls = CLS_HIGH;
        end else begin
            o_item.cls = CLS_MID;
        end
    end

    assign o_push = r_v3;

endmodule

/* design/cuvm_queue.sv */
`include "cell_undervoltage_monitor_assert.svh"

module cuvm_queue import cuvm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wvalid,
    output logic  o_wready,
    input  t_item i_wdata,
    output logic  o_rvalid,
    input  logic  i_rready,
    output t_item o_rdata
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   push, pop;

    assign o_wready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_rvalid = (r_count != '0);
    assign push     = i_wvalid && o_wready;
    assign pop      = o_rvalid && i_rready;
    assign o_rdata  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // pointers meet exactly when empty or full
    `CUVM_ASSERT_HOLD(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr)
    `CUVM_ASSERT_HOLD(a_full_ptrs, i_clk, i_rst_n, !o_wready, r_wr_ptr == r_rd_ptr)
    `CUVM_ASSERT_HOLD(a_ptrs_apart, i_clk, i_rst_n, o_rvalid && o_wready, r_wr_ptr != r_rd_ptr)

endmodule

/* design/cuvm_back.sv */
`include "cell_undervoltage_monitor_assert.svh"

module cuvm_back import cuvm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MV_W-1:0]    o_cell_mv,
    output logic               o_cell_faulted,
    output logic [FLAGS_W-1:0] o_fault_flags
);

    logic [COUNT_W-1:0]    r_low_count  [CELL_COUNT];
    logic [COUNT_W-1:0]    r_high_count [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_fault_bits;
    logic                  r_out_valid;
    logic [MV_W-1:0]       r_out_mv;
    logic                  r_out_faulted;
    logic [FLAGS_W-1:0]    r_out_flags;

    logic                  pop;
    logic [COUNT_W-1:0]    lc, hc;
    logic                  cur_fault;
    logic [COUNT_W-1:0]    n_lc, n_hc;
    logic [CELL_COUNT-1:0] n_fault_bits;
    logic                  n_faulted;

    // take the next item when the output slot is free or being emptied
    assign o_item_ready = !r_out_valid || i_ready;
    assign pop          = i_item_valid && o_item_ready;

    // per-cell debounce update
    always_comb begin
        lc           = i_item.idx_ok ? r_low_count[i_item.idx]  : '0;
        hc           = i_item.idx_ok ? r_high_count[i_item.idx] : '0;
        cur_fault    = i_item.idx_ok ? r_fault_bits[i_item.idx] : 1'b0;
        n_lc         = lc;
        n_hc         = hc;
        n_fault_bits = r_fault_bits;
        if (i_item.idx_ok) begin
            unique case (i_item.cls)
                CLS_LOW: begin
                    n_hc = '0;
                    if (lc < i_cfg.trip_count) begin
                        n_lc = lc + COUNT_W'(1);
                    end
                    if (n_lc >= i_cfg.trip_count) begin
                        n_fault_bits[i_item.idx] = 1'b1;
                    end
                end
                CLS_HIGH: begin
                    n_lc = '0;
                    if (cur_fault) begin
                        if (hc < i_cfg.clear_count) begin
                            n_hc = hc + COUNT_W'(1);
                        end
                        if (n_hc >= i_cfg.clear_count) begin
                            n_fault_bits[i_item.idx] = 1'b0;
                            n_hc                     = '0;
                        end
                    end
                end
                CLS_MID: begin
                    n_lc = '0;
                    n_hc = '0;
                end
                default: begin
                    n_lc = lc;
                    n_hc = hc;
                end
            endcase
        end
        n_faulted = i_item.idx_ok && n_fault_bits[i_item.idx];
    end

    // cell state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                r_low_count[i]  <= '0;
                r_high_count[i] <= '0;
            end
            r_fault_bits <= '0;
        end else if (pop && i_item.idx_ok) begin
            r_low_count[i_item.idx]  <= n_lc;
            r_high_count[i_item.idx] <= n_hc;
            r_fault_bits             <= n_fault_bits;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_item_ready) begin
            r_out_valid <= i_item_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_mv      <= i_item.mv;
            r_out_faulted <= n_faulted;
            r_out_flags   <= FLAGS_W'(n_fault_bits);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cell_mv      = r_out_mv;
    assign o_cell_faulted = r_out_faulted;
    assign o_fault_flags  = r_out_flags;

    // a healthy cell never carries a recovery count
    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell_chk
        `CUVM_ASSERT_HOLD(a_healthy_no_recovery, i_clk, i_rst_n, !r_fault_bits[g], r_high_count[g] == '0)
    end

    // an out-of-range reading leaves the faults alone and reports no fault
    `CUVM_ASSERT_NEXT(a_bad_index_quiet, i_clk, i_rst_n, pop && !i_item.idx_ok, !r_out_faulted && (r_fault_bits == $past(r_fault_bits)))

    // a faulted result shows up in the flag vector
    `CUVM_ASSERT_HOLD(a_fault_in_flags, i_clk, i_rst_n, r_out_valid && r_out_faulted, r_out_flags != '0)

endmodule

/* design/cell_undervoltage_monitor.sv */
// Battery cell undervoltage monitor. Each transfer on the input channel is one
// ADC reading (cell index, raw high and low bytes); each reading produces exactly
// one result transfer carrying the reading in millivolts (code*380/1000,
// truncated), the updated fault flag of that cell and all fault flags. The block
// accepts one reading per clock cycle and delivers one result per cycle while
// the result channel is not stalled by i_ready. That rate is set by the per-cell
// counter update, a read-modify-write with a registered write of the debounce
// counters in the back end; the millivolt conversion runs in a three-stage front
// pipeline feeding a two-entry queue. Readings for an index of 15 or more leave
// all state unchanged and report the cell as not faulted. Thresholds and counts
// live in four 32-bit APB registers at byte offsets 0x0 (undervoltage threshold),
// 0x4 (recovery level), 0x8 (trip count) and 0xC (clear count); write them only
// while no reading is in flight.
module cell_undervoltage_monitor import cuvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // reading channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CELL_IDX_W-1:0] i_cell_index,
    input  logic [RAW_W-1:0]      i_raw_high,
    input  logic [RAW_W-1:0]      i_raw_low,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [MV_W-1:0]       o_cell_mv,
    output logic                  o_cell_faulted,
    output logic [FLAGS_W-1:0]    o_fault_flags
);

    t_cfg       r_cfg;
    t_reg_index reg_idx;
    logic       wr_en;
    logic       push, push_ready;
    t_item      push_item;
    logic       q_valid, q_ready;
    t_item      q_item;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_index'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_threshold_mv   <= UV_THRESHOLD_RST;
            r_cfg.recovery_level_mv <= RECOVERY_LEVEL_RST;
            r_cfg.trip_count        <= TRIP_COUNT_RST;
            r_cfg.clear_count       <= CLEAR_COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_UV_THRESHOLD:   r_cfg.uv_threshold_mv   <= pwdata[MV_W-1:0];
                REG_RECOVERY_LEVEL: r_cfg.recovery_level_mv <= pwdata[MV_W-1:0];
                REG_TRIP_COUNT:     r_cfg.trip_count        <= pwdata[COUNT_W-1:0];
                REG_CLEAR_COUNT:    r_cfg.clear_count       <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_UV_THRESHOLD:   prdata = DATA_W'(r_cfg.uv_threshold_mv);
            REG_RECOVERY_LEVEL: prdata = DATA_W'(r_cfg.recovery_level_mv);
            REG_TRIP_COUNT:     prdata = DATA_W'(r_cfg.trip_count);
            REG_CLEAR_COUNT:    prdata = DATA_W'(r_cfg.clear_count);
            default:            prdata = '0;
        endcase
    end

    // conversion and classification
    cuvm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_index (i_cell_index),
        .i_raw_high   (i_raw_high),
        .i_raw_low    (i_raw_low),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    // decoupling queue
    cuvm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (push),
        .o_wready (push_ready),
        .i_wdata  (push_item),
        .o_rvalid (q_valid),
        .i_rready (q_ready),
        .o_rdata  (q_item)
    );

    // debounce state and result register
    cuvm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (q_valid),
        .o_item_ready   (q_ready),
        .i_item         (q_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_mv      (o_cell_mv),
        .o_cell_faulted (o_cell_faulted),
        .o_fault_flags  (o_fault_flags)
    );

endmodule

/* tb/cuvm_tb_pkg.sv */
package cuvm_tb_pkg;
    import cuvm_pkg::*;

    // one predicted result transfer
    typedef struct packed {
        logic [MV_W-1:0]    mv;
        logic               faulted;
        logic [FLAGS_W-1:0] flags;
    } t_cell_result;

    // millivolts of a 14-bit adc code, truncated
    function automatic int unsigned code_to_mv(logic [CODE_W-1:0] code);
        int unsigned c;
        c = code;
        return (c * 380) / 1000;
    endfunction

    // mirror of the debounce state and register settings
    class cell_fault_tracker;
        logic [MV_W-1:0]    thr_mv;
        logic [MV_W-1:0]    rec_mv;
        logic [COUNT_W-1:0] trip_cnt;
        logic [COUNT_W-1:0] clear_cnt;
        logic [COUNT_W-1:0] low_cnt [CELL_COUNT];
        logic [COUNT_W-1:0] high_cnt [CELL_COUNT];
        logic [FLAGS_W-1:0] faults;
        t_cell_result       pending_results [$];

        function new();
            thr_mv    = UV_THRESHOLD_RST;
            rec_mv    = RECOVERY_LEVEL_RST;
            trip_cnt  = TRIP_COUNT_RST;
            clear_cnt = CLEAR_COUNT_RST;
            foreach (low_cnt[i]) begin
                low_cnt[i]  = '0;
                high_cnt[i] = '0;
            end
            faults = '0;
        endfunction

        // register write, masked to the register width
        function void set_reg(t_reg_index idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_UV_THRESHOLD:   thr_mv    = value[MV_W-1:0];
                REG_RECOVERY_LEVEL: rec_mv    = value[MV_W-1:0];
                REG_TRIP_COUNT:     trip_cnt  = value[COUNT_W-1:0];
                REG_CLEAR_COUNT:    clear_cnt = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // update the cell state for one accepted reading and queue its result
        function void note_reading(logic [CELL_IDX_W-1:0] idx, logic [RAW_W-1:0] hi,
                                   logic [RAW_W-1:0] lo);
            t_cell_result r;
            int unsigned  mv;
            mv = code_to_mv({hi[CODE_HI_W-1:0], lo});
            r.faulted = 1'b0;
            if (idx < CELL_COUNT) begin
                // low test comes first and wins over the recovery test
                if (mv < thr_mv) begin
                    high_cnt[idx] = '0;
                    if (low_cnt[idx] < trip_cnt)
                        low_cnt[idx] = low_cnt[idx] + 1'b1;
                    if (low_cnt[idx] >= trip_cnt)
                        faults[idx] = 1'b1;
                end else if (mv > rec_mv) begin
                    low_cnt[idx] = '0;
                    if (faults[idx]) begin
                        if (high_cnt[idx] < clear_cnt)
                            high_cnt[idx] = high_cnt[idx] + 1'b1;
                        if (high_cnt[idx] >= clear_cnt) begin
                            faults[idx]   = 1'b0;
                            high_cnt[idx] = '0;
                        end
                    end
                end else begin
                    low_cnt[idx]  = '0;
                    high_cnt[idx] = '0;
                end
                r.faulted = faults[idx];
            end
            r.mv    = mv[MV_W-1:0];
            r.flags = faults;
            pending_results.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction; empty string on match
        function string check_result(logic [MV_W-1:0] mv, logic faulted,
                                     logic [FLAGS_W-1:0] flags);
            t_cell_result r;
            string        msg;
            if (pending_results.size() == 0)
                return " result transfer with no reading outstanding";
            r   = pending_results.pop_front();
            msg = "";
            if (mv !== r.mv)
                msg = {msg, $sformatf(" cell_mv got %0d want %0d", mv, r.mv)};
            if (faulted !== r.faulted)
                msg = {msg, $sformatf(" cell_faulted got %0b want %0b", faulted, r.faulted)};
            if (flags !== r.flags)
                msg = {msg, $sformatf(" fault_flags got %h want %h", flags, r.flags)};
            return msg;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cuvm_pkg::*;
    import cuvm_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CODE_MAX      = (1 << CODE_W) - 1;

    typedef enum int {
        RD_LOW,
        RD_HIGH,
        RD_MID
    } t_kind;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_W-1:0]     paddr        = '0;
    logic [DATA_W-1:0]     pwdata       = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [CELL_IDX_W-1:0] i_cell_index = '0;
    logic [RAW_W-1:0]      i_raw_high   = '0;
    logic [RAW_W-1:0]      i_raw_low    = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [MV_W-1:0]       o_cell_mv;
    logic                  o_cell_faulted;
    logic [FLAGS_W-1:0]    o_fault_flags;

    cell_fault_tracker tracker = new();

    int errors   = 0;
    int cycles   = 0;
    int rx_stall = 0;
    bit tx_calm  = 1'b0;
    bit rx_calm  = 1'b0;

    always #5 i_clk = ~i_clk;

    cell_undervoltage_monitor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cell_index   (i_cell_index),
        .i_raw_high     (i_raw_high),
        .i_raw_low      (i_raw_low),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_mv      (o_cell_mv),
        .o_cell_faulted (o_cell_faulted),
        .o_fault_flags  (o_fault_flags)
    );

    task automatic report_mismatch(string msg);
        $display("tb_top mismatch at cycle %0d:%s", cycles, msg);
        errors++;
    endtask

    // note accepted readings, check accepted results
    always @(posedge i_clk) begin : transfer_monitor
        string msg;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.note_reading(i_cell_index, i_raw_high, i_raw_low);
            if (o_valid && i_ready) begin
                msg = tracker.check_result(o_cell_mv, o_cell_faulted, o_fault_flags);
                if (msg != "")
                    report_mismatch(msg);
            end
        end
    end

    // result side back-pressure, mostly short stalls and a few long ones
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            i_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (!rx_calm && $urandom_range(0, 99) < 15) begin
            i_ready  <= 1'b0;
            rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // random code whose millivolt value falls in the wanted band, when one exists
    function automatic logic [CODE_W-1:0] pick_code(t_kind kind);
        int              lo_c;
        int              hi_c;
        int              t_c;
        int              r_c;
        int unsigned     mv;
        bit              hit;
        logic [CODE_W-1:0] code;
        t_c = int'(tracker.thr_mv) * 50 / 19;
        r_c = int'(tracker.rec_mv) * 50 / 19;
        case (kind)
            RD_LOW:  begin lo_c = 0;       hi_c = t_c + 3;  end
            RD_HIGH: begin lo_c = r_c;     hi_c = CODE_MAX; end
            default: begin lo_c = t_c - 3; hi_c = r_c + 3;  end
        endcase
        if (lo_c < 0) lo_c = 0;
        if (hi_c > CODE_MAX) hi_c = CODE_MAX;
        if (lo_c > CODE_MAX) lo_c = CODE_MAX;
        if (lo_c > hi_c) begin
            lo_c = 0;
            hi_c = CODE_MAX;
        end
        code = '0;
        for (int k = 0; k < 16; k++) begin
            code = CODE_W'($urandom_range(hi_c, lo_c));
            mv   = code_to_mv(code);
            case (kind)
                RD_LOW:  hit = mv < tracker.thr_mv;
                RD_HIGH: hit = mv >= tracker.thr_mv && mv > tracker.rec_mv;
                default: hit = mv >= tracker.thr_mv && mv <= tracker.rec_mv;
            endcase
            if (hit)
                return code;
        end
        return code;
    endfunction

    // one apb write; the caller drops psel after its last write
    task automatic apb_write(t_reg_index idx, logic [DATA_W-1:0] value, int width);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        // unused upper bits sometimes set, the register keeps only its width
        if ($urandom_range(0, 3) == 0)
            value = value | (junk << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
    endtask

    task automatic set_config(int thr, int rec, int trip, int clr);
        apb_write(REG_UV_THRESHOLD, DATA_W'(thr), MV_W);
        apb_write(REG_RECOVERY_LEVEL, DATA_W'(rec), MV_W);
        apb_write(REG_TRIP_COUNT, DATA_W'(trip), COUNT_W);
        apb_write(REG_CLEAR_COUNT, DATA_W'(clr), COUNT_W);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // present one reading and hold it until the transfer
    task automatic send_reading(logic [CELL_IDX_W-1:0] idx, logic [RAW_W-1:0] hi,
                                logic [RAW_W-1:0] lo, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_index <= idx;
        i_raw_high   <= hi;
        i_raw_low    <= lo;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // reading of an exact millivolt value, unused adc bits random
    task automatic send_mv(logic [CELL_IDX_W-1:0] idx, int mv);
        int                code_i;
        logic [CODE_W-1:0] code;
        code_i = (mv * 50 + 18) / 19;
        if (code_i > CODE_MAX)
            code_i = CODE_MAX;
        code = CODE_W'(code_i);
        send_reading(idx, {2'($urandom), code[13:8]}, code[7:0], pick_gap());
    endtask

    task automatic send_kind(logic [CELL_IDX_W-1:0] idx, t_kind kind);
        logic [CODE_W-1:0] code;
        code = pick_code(kind);
        send_reading(idx, {2'($urandom), code[13:8]}, code[7:0], pick_gap());
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // runs of same-kind readings per cell, mixed with noise readings
    task automatic run_phase(int n_items, bit calm, int hold_at, int noise_pct);
        int    sent;
        int    len;
        int    cnt;
        int    r;
        int    cell_sel;
        t_kind kind;
        sent     = 0;
        cell_sel = 0;
        tx_calm  = calm;
        rx_calm  = calm;
        while (sent < n_items) begin
            if ($urandom_range(0, 1) == 0)
                cell_sel = $urandom_range(0, CELL_COUNT - 1);
            r    = $urandom_range(0, 99);
            kind = (r < 40) ? RD_LOW : (r < 80) ? RD_HIGH : RD_MID;
            cnt  = (kind == RD_LOW) ? int'(tracker.trip_cnt) :
                   (kind == RD_HIGH) ? int'(tracker.clear_cnt) : 1;
            len  = $urandom_range(1, cnt + 2);
            for (int k = 0; k < len && sent < n_items; k++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    send_reading(4'($urandom), 8'($urandom), 8'($urandom), pick_gap());
                    sent++;
                end
                send_kind(4'(cell_sel), kind);
                sent++;
                // sender holds off until everything is out
                if (hold_at > 0 && sent >= hold_at) begin
                    wait_idle();
                    hold_at = 0;
                end
            end
            // occasionally break a run on the same cell
            if ($urandom_range(0, 9) == 0) begin
                send_kind(4'(cell_sel), t_kind'($urandom_range(0, 2)));
                sent++;
            end
        end
    endtask

    initial begin
        int thr;
        int rec;
        int trip;
        int clr;
        int n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extreme codes, out-of-range cell, band edges
        send_reading(4'd0, 8'h00, 8'h00, pick_gap());
        send_reading(4'd14, 8'hFF, 8'hFF, pick_gap());
        send_mv(4'd15, 100);
        send_mv(4'd7, 2900);
        send_mv(4'd7, 2800);
        send_mv(4'd7, 3000);
        wait_idle();

        // zero counts act on the first reading
        set_config(2800, 3000, 0, 0);
        send_mv(4'd3, 100);
        send_mv(4'd15, 100);
        send_mv(4'd3, 3001);
        send_mv(4'd3, 2799);
        send_mv(4'd3, 2900);
        wait_idle();

        // small counts, leave counters part way
        set_config(2800, 3000, 3, 2);
        send_mv(4'd5, 0);
        send_mv(4'd5, 0);
        send_mv(4'd5, 0);
        send_mv(4'd5, 4000);
        send_mv(4'd6, 1000);
        send_mv(4'd6, 1000);
        wait_idle();

        // counts lowered below counters, threshold above recovery level
        set_config(4000, 1000, 1, 1);
        send_mv(4'd6, 500);
        send_mv(4'd5, 5000);
        send_mv(4'd9, 2000);
        wait_idle();

        // random phases over several settings
        for (int p = 0; p < 8; p++) begin
            n = 200;
            case (p)
                0: set_config(2800, 3000, 30, 60);
                5: set_config(8191, 0, 2, 2);
                6: set_config(0, 0, 1, 1);
                7: begin
                    set_config(3000, 3200, 255, 255);
                    n = 480;
                end
                default: begin
                    thr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1500, 4500);
                    case ($urandom_range(0, 3))
                        0:       rec = $urandom_range(0, 6225);
                        1:       rec = 6225;
                        default: rec = thr + $urandom_range(0, 600);
                    endcase
                    trip = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    clr  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    set_config(thr, rec, trip, clr);
                end
            endcase
            run_phase(n, p == 1 || p == 4, (p == 2) ? 100 : 0, (p == 7) ? 0 : 20);
            wait_idle();
        end

        if (tracker.pending() != 0)
            report_mismatch(" predicted results left over");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
